// ===== rtl/core/fjvi_pkg.sv =====
`timescale 1ns / 1ps

package fjvi_pkg;

    // Width of the exact intermediate arithmetic and of one multiplier limb.
    localparam int WW      = 256;
    localparam int LIMB_W  = 32;
    localparam int ACC_W   = 64;
    localparam int COF_W   = 129;
    localparam int NUM_ENT = 9;

    // Operand sources for the wide multiply-accumulate unit.
    localparam logic [1:0] SRC_JAC = 2'd0;
    localparam logic [1:0] SRC_COF = 2'd1;
    localparam logic [1:0] SRC_DET = 2'd2;
    localparam logic [1:0] SRC_WGT = 2'd3;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic [30:0]        quad_weight;
        logic               last_vertex;
    } in_item_t;

    typedef struct packed {
        logic [30:0]        volume;
        logic signed [31:0] inv_r0c0;
        logic signed [31:0] inv_r0c1;
        logic signed [31:0] inv_r0c2;
        logic signed [31:0] inv_r1c0;
        logic signed [31:0] inv_r1c1;
        logic signed [31:0] inv_r1c2;
        logic signed [31:0] inv_r2c0;
        logic signed [31:0] inv_r2c1;
        logic signed [31:0] inv_r2c2;
        logic               singular;
    } out_item_t;

    // One step of the wide product programme.
    typedef struct packed {
        logic [1:0] src_a;
        logic [3:0] idx_a;
        logic [1:0] src_b;
        logic [3:0] idx_b;
        logic       neg;
        logic       clr;
        logic       st_cof;
        logic       st_det;
        logic       st_vol;
    } op_t;

    typedef struct packed {
        logic       capture;
        logic       acc_mul;
        logic       acc_clear;
        logic       clr_wide;
        logic       ld_a;
        logic       ld_b;
        logic [1:0] src;
        logic [3:0] idx;
        logic       mul_issue;
        logic [2:0] li;
        logic [2:0] lj;
        logic       neg;
        logic       st_cof;
        logic       st_det;
        logic       st_vol;
        logic       div_ld;
        logic       div_step;
        logic       div_st;
        logic       out_load;
        logic       out_singular;
    } dp_cmd_t;

    typedef struct packed {
        logic last_vertex;
        logic det_zero;
    } dp_sts_t;

    localparam logic [4:0] OP_FIRST_DET = 5'd18;
    localparam logic [4:0] OP_VOL       = 5'd21;

    // Jacobian indices {a, b, c, d} of cofactor n: C = Ja*Jb - Jc*Jd.
    function automatic logic [15:0] cof_terms(input logic [3:0] n);
        case (n)
            4'd0:    cof_terms = 16'h4857;
            4'd1:    cof_terms = 16'h5638;
            4'd2:    cof_terms = 16'h3746;
            4'd3:    cof_terms = 16'h7281;
            4'd4:    cof_terms = 16'h8062;
            4'd5:    cof_terms = 16'h6170;
            4'd6:    cof_terms = 16'h1524;
            4'd7:    cof_terms = 16'h2305;
            4'd8:    cof_terms = 16'h0413;
            default: cof_terms = 16'h0000;
        endcase
    endfunction

    function automatic op_t op_decode(input logic [4:0] op);
        op_t         d;
        logic [15:0] t;
        d = '0;
        t = cof_terms(op[4:1]);
        if (op < OP_FIRST_DET) begin
            d.src_a = SRC_JAC;
            d.src_b = SRC_JAC;
            if (!op[0]) begin
                d.idx_a = t[15:12];
                d.idx_b = t[11:8];
                d.clr   = 1'b1;
            end else begin
                d.idx_a  = t[7:4];
                d.idx_b  = t[3:0];
                d.neg    = 1'b1;
                d.st_cof = 1'b1;
            end
        end else if (op < OP_VOL) begin
            d.src_a  = SRC_JAC;
            d.src_b  = SRC_COF;
            d.idx_a  = 4'(op - OP_FIRST_DET);
            d.idx_b  = 4'(op - OP_FIRST_DET);
            d.clr    = (op == OP_FIRST_DET);
            d.st_det = (op == OP_VOL - 5'd1);
        end else begin
            d.src_a  = SRC_DET;
            d.src_b  = SRC_WGT;
            d.clr    = 1'b1;
            d.st_vol = 1'b1;
        end
        return d;
    endfunction

    function automatic logic [2:0] src_limbs(input logic [1:0] src);
        case (src)
            SRC_JAC: src_limbs = 3'd2;
            SRC_COF: src_limbs = 3'd4;
            SRC_DET: src_limbs = 3'd6;
            default: src_limbs = 3'd1;
        endcase
    endfunction

    function automatic logic [1:0] ent_row(input logic [3:0] k);
        case (k)
            4'd0, 4'd1, 4'd2: ent_row = 2'd0;
            4'd3, 4'd4, 4'd5: ent_row = 2'd1;
            default:          ent_row = 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] ent_col(input logic [3:0] k);
        case (k)
            4'd0, 4'd3, 4'd6: ent_col = 2'd0;
            4'd1, 4'd4, 4'd7: ent_col = 2'd1;
            default:          ent_col = 2'd2;
        endcase
    endfunction

    function automatic logic [3:0] transpose_idx(input logic [3:0] e);
        case (e)
            4'd1:    transpose_idx = 4'd3;
            4'd2:    transpose_idx = 4'd6;
            4'd3:    transpose_idx = 4'd1;
            4'd5:    transpose_idx = 4'd7;
            4'd6:    transpose_idx = 4'd2;
            4'd7:    transpose_idx = 4'd5;
            default: transpose_idx = e;
        endcase
    endfunction

    function automatic logic [WW-1:0] f_abs(input logic [WW-1:0] x);
        return x[WW-1] ? (~x + WW'(1)) : x;
    endfunction

endpackage

// ===== rtl/core/fem_jacobian_volume_inverse.sv =====
`timescale 1ns / 1ps

// Jacobian, volume and inverse Jacobian for one quadrature point of a finite
// element. Each input transaction carries one vertex (position and
// shape-function gradient, signed Q16.16); the block adds the outer product
// into a saturating 64-bit 3x3 Jacobian. The transaction flagged last_vertex
// produces one result transaction: |det J| times the quadrature weight, and
// inv(J) in Q16.16, each truncated and saturated, or zeros with singular set
// when the determinant is exactly zero. The accumulator is cleared once the
// result has been handed to the output register. A vertex that does not end
// the run uses the single 33x33 multiplier, which forms the nine products
// one per cycle. The closing vertex then runs a programme on the same
// multiplier, one 32x32 limb product per cycle, for the nine cofactors, the
// determinant and the volume, followed by nine restoring divisions. A
// finished result waits in the output register while the next run is
// accepted and accumulated.
module fem_jacobian_volume_inverse #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fjvi_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output fjvi_pkg::out_item_t m_payload
);
    import fjvi_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    dp_cmd_t cmd;
    dp_sts_t sts;

    fjvi_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    fjvi_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_payload),
        .cmd     (cmd),
        .sts     (sts),
        .m_item  (m_payload)
    );

endmodule

// ===== rtl/core/fjvi_ctrl.sv =====
`timescale 1ns / 1ps

module fjvi_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output fjvi_pkg::dp_cmd_t cmd,
    input  fjvi_pkg::dp_sts_t sts
);
    import fjvi_pkg::*;

    localparam int IN_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int K    = IN_W - 1;
    localparam int DS_W = $clog2(IN_W);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ACC     = 4'd1;
    localparam logic [3:0] S_LDA     = 4'd2;
    localparam logic [3:0] S_LDB     = 4'd3;
    localparam logic [3:0] S_MUL     = 4'd4;
    localparam logic [3:0] S_DRAIN   = 4'd5;
    localparam logic [3:0] S_STORE   = 4'd6;
    localparam logic [3:0] S_DIVLD   = 4'd7;
    localparam logic [3:0] S_DIVSTEP = 4'd8;
    localparam logic [3:0] S_DIVST   = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0]      state_reg, state_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [4:0]      op_reg, op_next;
    logic [2:0]      li_reg, li_next, lj_reg, lj_next;
    logic [2:0]      na_reg, na_next, nb_reg, nb_next;
    logic [3:0]      e_reg, e_next;
    logic [DS_W-1:0] ds_reg, ds_next;
    logic            mv_reg, mv_next;
    logic            sing_reg, sing_next;
    op_t             cur_op;

    assign cur_op  = op_decode(op_reg);
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        li_next    = li_reg;
        lj_next    = lj_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        e_next     = e_reg;
        ds_next    = ds_reg;
        sing_next  = sing_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_ACC;
                end
            end
            S_ACC: begin
                if (cnt_reg != 4'(NUM_ENT)) begin
                    cmd.acc_mul = 1'b1;
                    cmd.idx     = cnt_reg;
                    cnt_next    = cnt_reg + 4'd1;
                end else if (sts.last_vertex) begin
                    op_next    = '0;
                    state_next = S_LDA;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_LDA: begin
                cmd.ld_a     = 1'b1;
                cmd.src      = cur_op.src_a;
                cmd.idx      = cur_op.idx_a;
                cmd.clr_wide = cur_op.clr;
                na_next      = src_limbs(cur_op.src_a);
                state_next   = S_LDB;
            end
            S_LDB: begin
                cmd.ld_b   = 1'b1;
                cmd.src    = cur_op.src_b;
                cmd.idx    = cur_op.idx_b;
                nb_next    = src_limbs(cur_op.src_b);
                li_next    = '0;
                lj_next    = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul_issue = 1'b1;
                cmd.li        = li_reg;
                cmd.lj        = lj_reg;
                cmd.neg       = cur_op.neg;
                if (lj_reg == nb_reg - 3'd1) begin
                    lj_next = '0;
                    if (li_reg == na_reg - 3'd1) begin
                        state_next = S_DRAIN;
                    end else begin
                        li_next = li_reg + 3'd1;
                    end
                end else begin
                    lj_next = lj_reg + 3'd1;
                end
            end
            S_DRAIN: begin
                state_next = S_STORE;
            end
            S_STORE: begin
                cmd.st_cof = cur_op.st_cof;
                cmd.st_det = cur_op.st_det;
                cmd.st_vol = cur_op.st_vol;
                cmd.idx    = op_reg[4:1];
                if (cur_op.st_vol) begin
                    e_next     = '0;
                    state_next = S_DIVLD;
                end else if (cur_op.st_det && sts.det_zero) begin
                    sing_next  = 1'b1;
                    state_next = S_OUT;
                end else begin
                    op_next    = op_reg + 5'd1;
                    state_next = S_LDA;
                end
            end
            S_DIVLD: begin
                cmd.div_ld = 1'b1;
                cmd.src    = SRC_COF;
                cmd.idx    = transpose_idx(e_reg);
                ds_next    = '0;
                state_next = S_DIVSTEP;
            end
            S_DIVSTEP: begin
                cmd.div_step = 1'b1;
                if (ds_reg == DS_W'(K)) begin
                    state_next = S_DIVST;
                end else begin
                    ds_next = ds_reg + DS_W'(1);
                end
            end
            S_DIVST: begin
                cmd.div_st = 1'b1;
                cmd.idx    = e_reg;
                if (e_reg == 4'(NUM_ENT - 1)) begin
                    sing_next  = 1'b0;
                    state_next = S_OUT;
                end else begin
                    e_next     = e_reg + 4'd1;
                    state_next = S_DIVLD;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_singular = sing_reg;
                    cmd.acc_clear    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            mv_next = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end else begin
            mv_next = mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            op_reg    <= '0;
            li_reg    <= '0;
            lj_reg    <= '0;
            na_reg    <= 3'd1;
            nb_reg    <= 3'd1;
            e_reg     <= '0;
            ds_reg    <= '0;
            mv_reg    <= 1'b0;
            sing_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
            li_reg    <= li_next;
            lj_reg    <= lj_next;
            na_reg    <= na_next;
            nb_reg    <= nb_next;
            e_reg     <= e_next;
            ds_reg    <= ds_next;
            mv_reg    <= mv_next;
            sing_reg  <= sing_next;
        end
    end

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mv_reg || m_ready))
        else $error("result overwritten while still waiting");

    a_limb_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (li_reg < na_reg && lj_reg < nb_reg))
        else $error("limb counter beyond operand length");

    a_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_ACC))
        else $error("accepted transaction not accumulated");

endmodule

// ===== rtl/core/fjvi_dp.sv =====
`timescale 1ns / 1ps

module fjvi_dp #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fjvi_pkg::in_item_t  s_item,
    input  fjvi_pkg::dp_cmd_t   cmd,
    output fjvi_pkg::dp_sts_t   sts,
    output fjvi_pkg::out_item_t m_item
);
    import fjvi_pkg::*;

    localparam int IN_W  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int VOL_W = (DATA_WIDTH - 1 < 31) ? DATA_WIDTH - 1 : 31;
    localparam int K     = IN_W - 1;

    in_item_t           in_reg;
    out_item_t          out_reg;
    logic signed [63:0] acc_reg [NUM_ENT];
    logic [COF_W-1:0]   cof_reg [NUM_ENT];
    logic [31:0]        inv_reg [NUM_ENT];
    logic [63:0]        pp_reg;
    logic               pp_acc_vld_reg;
    logic [3:0]         pp_acc_idx_reg;
    logic               pp_w_vld_reg;
    logic               pp_sub_reg;
    logic [3:0]         pp_shift_reg;
    logic [WW-1:0]      wacc_reg, opa_reg, opb_reg, det_mag_reg, rem_reg, dsh_reg;
    logic               sa_reg, sb_reg, det_neg_reg, dneg_reg;
    logic [IN_W-1:0]    q_reg;
    logic [30:0]        vol_reg;

    logic [3:0]         rd_idx;
    logic signed [63:0] jac_rd;
    logic [COF_W-1:0]   cof_rd;
    logic [WW-1:0]      src_val, src_mag;
    logic               src_neg;
    logic [31:0]        pos_sel, grad_sel;
    logic signed [32:0] ma, mb;
    logic signed [65:0] mprod;
    logic [64:0]        acc_sum;
    logic signed [63:0] acc_new;
    logic [WW-1:0]      pp_ext, vsh;
    logic               rem_ge;
    logic [IN_W-1:0]    qres;
    logic [30:0]        vol_new;

    assign sts.last_vertex = in_reg.last_vertex;
    assign sts.det_zero    = (wacc_reg == '0);
    assign m_item          = out_reg;

    // One read port on the Jacobian registers, shared by accumulation and loads.
    assign rd_idx = pp_acc_vld_reg ? pp_acc_idx_reg : cmd.idx;
    assign jac_rd = acc_reg[rd_idx];
    assign cof_rd = cof_reg[cmd.idx];

    always_comb begin
        case (cmd.src)
            SRC_JAC: src_val = WW'(jac_rd);
            SRC_COF: src_val = WW'(signed'(cof_rd));
            SRC_DET: src_val = det_mag_reg;
            default: src_val = WW'(in_reg.quad_weight);
        endcase
        src_neg = src_val[WW-1];
        src_mag = f_abs(src_val);
    end

    always_comb begin
        case (ent_row(cmd.idx))
            2'd0:    pos_sel = in_reg.pos_x;
            2'd1:    pos_sel = in_reg.pos_y;
            default: pos_sel = in_reg.pos_z;
        endcase
        case (ent_col(cmd.idx))
            2'd0:    grad_sel = in_reg.grad_x;
            2'd1:    grad_sel = in_reg.grad_y;
            default: grad_sel = in_reg.grad_z;
        endcase
        if (cmd.acc_mul) begin
            ma = 33'(signed'(pos_sel[IN_W-1:0]));
            mb = 33'(signed'(grad_sel[IN_W-1:0]));
        end else begin
            ma = signed'({1'b0, opa_reg[cmd.li*LIMB_W +: LIMB_W]});
            mb = signed'({1'b0, opb_reg[cmd.lj*LIMB_W +: LIMB_W]});
        end
        mprod = ma * mb;
    end

    // Saturating 64-bit Jacobian accumulation.
    always_comb begin
        acc_sum = {jac_rd[63], jac_rd} + {pp_reg[63], pp_reg};
        if (acc_sum[64] != acc_sum[63]) begin
            acc_new = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            acc_new = signed'(acc_sum[63:0]);
        end
    end

    always_comb begin
        pp_ext  = WW'(pp_reg) << {pp_shift_reg, 5'd0};
        vsh     = wacc_reg >> (6 * FRAC_BITS);
        vol_new = ((vsh >> VOL_W) != '0) ? ((31'd1 << VOL_W) - 31'd1) : vsh[30:0];
        rem_ge  = (rem_reg >= dsh_reg);
        if (q_reg[K]) begin
            qres = dneg_reg ? {1'b1, {K{1'b0}}} : {1'b0, {K{1'b1}}};
        end else begin
            qres = dneg_reg ? (~q_reg + IN_W'(1)) : q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_acc_vld_reg <= 1'b0;
            pp_w_vld_reg   <= 1'b0;
            for (int i = 0; i < NUM_ENT; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            pp_acc_vld_reg <= cmd.acc_mul;
            pp_w_vld_reg   <= cmd.mul_issue;
            if (cmd.acc_clear) begin
                for (int i = 0; i < NUM_ENT; i++) begin
                    acc_reg[i] <= '0;
                end
            end else if (pp_acc_vld_reg) begin
                acc_reg[pp_acc_idx_reg] <= acc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pp_reg         <= mprod[63:0];
        pp_acc_idx_reg <= cmd.idx;
        pp_sub_reg     <= sa_reg ^ sb_reg ^ cmd.neg;
        pp_shift_reg   <= {1'b0, cmd.li} + {1'b0, cmd.lj};
        if (cmd.capture) begin
            in_reg <= s_item;
        end
        if (cmd.ld_a) begin
            opa_reg <= src_mag;
            sa_reg  <= src_neg;
        end
        if (cmd.ld_b) begin
            opb_reg <= src_mag;
            sb_reg  <= src_neg;
        end
        if (cmd.clr_wide) begin
            wacc_reg <= '0;
        end else if (pp_w_vld_reg) begin
            wacc_reg <= pp_sub_reg ? (wacc_reg - pp_ext) : (wacc_reg + pp_ext);
        end
        if (cmd.st_cof) begin
            cof_reg[cmd.idx] <= wacc_reg[COF_W-1:0];
        end
        if (cmd.st_det) begin
            det_neg_reg <= wacc_reg[WW-1];
            det_mag_reg <= f_abs(wacc_reg);
        end
        if (cmd.st_vol) begin
            vol_reg <= vol_new;
        end
        if (cmd.div_ld) begin
            rem_reg  <= src_mag << (3 * FRAC_BITS);
            dsh_reg  <= det_mag_reg << K;
            q_reg    <= '0;
            dneg_reg <= src_neg ^ det_neg_reg;
        end else if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[K-1:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.div_st) begin
            inv_reg[cmd.idx] <= 32'(signed'(qres));
        end
        if (cmd.out_load) begin
            if (cmd.out_singular) begin
                out_reg <= '{singular: 1'b1, default: '0};
            end else begin
                out_reg.volume   <= vol_reg;
                out_reg.inv_r0c0 <= inv_reg[0];
                out_reg.inv_r0c1 <= inv_reg[1];
                out_reg.inv_r0c2 <= inv_reg[2];
                out_reg.inv_r1c0 <= inv_reg[3];
                out_reg.inv_r1c1 <= inv_reg[4];
                out_reg.inv_r1c2 <= inv_reg[5];
                out_reg.inv_r2c0 <= inv_reg[6];
                out_reg.inv_r2c1 <= inv_reg[7];
                out_reg.inv_r2c2 <= inv_reg[8];
                out_reg.singular <= 1'b0;
            end
        end
    end

    a_pp_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pp_acc_vld_reg && pp_w_vld_reg))
        else $error("accumulator and wide product in flight together");

    a_det_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.st_det |=> !det_mag_reg[WW-1])
        else $error("determinant magnitude has its sign bit set");

endmodule
